@@ design/gfdrp_pkg.sv @@
// Shared types, constants and helpers for the GPS fix delta record packer.
`timescale 1ns / 1ps

package gfdrp_pkg;

  // Sector geometry in bytes
  localparam int SECTOR_BYTES  = 512;
  localparam int HEADER_BYTES  = 16;
  localparam int CONTROL_BYTES = 24;
  localparam int DIFF_BYTES    = 5;

  localparam int OFS_W = $clog2(SECTOR_BYTES + 1);
  typedef logic [OFS_W-1:0] ofs_t;

  localparam ofs_t OFS_HEADER = OFS_W'(HEADER_BYTES);
  localparam ofs_t OFS_CTRL   = OFS_W'(CONTROL_BYTES);
  localparam ofs_t OFS_DIFF   = OFS_W'(DIFF_BYTES);
  localparam ofs_t LIM_CTRL   = OFS_W'(SECTOR_BYTES - CONTROL_BYTES);
  localparam ofs_t LIM_DIFF   = OFS_W'(SECTOR_BYTES - DIFF_BYTES);
  localparam ofs_t OFS_SECTOR = OFS_W'(SECTOR_BYTES);

  localparam int          COORD_LIMIT = 180000000;
  localparam logic [31:0] TIME_LOW    = 32'd1262304000;
  localparam logic [31:0] TIME_HIGH   = 32'd2524608000;

  typedef enum logic [1:0] {
    ST_STORED  = 2'd0,
    ST_FLUSHED = 2'd1,
    ST_SAME    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  localparam logic KIND_DIFF = 1'b0;
  localparam logic KIND_CTRL = 1'b1;

  typedef struct packed {
    logic signed [31:0] lat_microdeg;
    logic signed [31:0] lon_microdeg;
    logic signed [23:0] alt_decimetres;
    logic        [11:0] course_tenths;
    logic        [15:0] speed_tenths;
    logic        [31:0] time_seconds;
  } fix_t;

  typedef struct packed {
    status_t            status;
    logic               frame_kind;
    logic        [6:0]  record_slot;
    logic        [6:0]  flushed_count;
    logic signed [7:0]  delta_lat;
    logic signed [7:0]  delta_lon;
    logic signed [7:0]  delta_alt;
    logic signed [7:0]  delta_course;
    logic signed [7:0]  delta_speed;
  } rec_t;

  // Last stored fix plus sector tracker
  typedef struct packed {
    logic signed [31:0] lat;
    logic signed [31:0] lon;
    logic signed [23:0] alt;
    logic        [11:0] course;
    logic        [15:0] speed;
    logic        [31:0] time_s;
    ofs_t               offset;
    logic        [6:0]  count;
    logic               have;
  } state_t;

  typedef struct packed {
    logic   store;
    rec_t   rec;
    state_t st_nxt;
  } eval_t;

  // True when a delta fits the diff record range of plus or minus 127
  function automatic logic delta_small(input logic signed [32:0] d);
    return (d >= -33'sd127) && (d <= 33'sd127);
  endfunction

endpackage

@@ design/gfdrp_fix_if.sv @@
// Valid/ready channel carrying one GPS fix.
`timescale 1ns / 1ps

interface gfdrp_fix_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] lat_microdeg;
  logic signed [31:0] lon_microdeg;
  logic signed [23:0] alt_decimetres;
  logic        [11:0] course_tenths;
  logic        [15:0] speed_tenths;
  logic        [31:0] time_seconds;

  modport source (
    output valid, lat_microdeg, lon_microdeg, alt_decimetres,
           course_tenths, speed_tenths, time_seconds,
    input  ready
  );
  modport sink (
    input  valid, lat_microdeg, lon_microdeg, alt_decimetres,
           course_tenths, speed_tenths, time_seconds,
    output ready
  );
endinterface

@@ design/gfdrp_rec_if.sv @@
// Valid/ready channel carrying one packed record descriptor.
`timescale 1ns / 1ps

interface gfdrp_rec_if;
  logic              valid;
  logic              ready;
  logic        [1:0] status;
  logic              frame_kind;
  logic        [6:0] record_slot;
  logic        [6:0] flushed_count;
  logic signed [7:0] delta_lat;
  logic signed [7:0] delta_lon;
  logic signed [7:0] delta_alt;
  logic signed [7:0] delta_course;
  logic signed [7:0] delta_speed;

  modport source (
    output valid, status, frame_kind, record_slot, flushed_count,
           delta_lat, delta_lon, delta_alt, delta_course, delta_speed,
    input  ready
  );
  modport sink (
    input  valid, status, frame_kind, record_slot, flushed_count,
           delta_lat, delta_lon, delta_alt, delta_course, delta_speed,
    output ready
  );
endinterface

@@ design/gps_fix_delta_record_packer_core.sv @@
// Top level of the GPS fix delta record packer.
`timescale 1ns / 1ps

// GPS fix delta record packer.
// in_ch takes one fix per transfer (position, altitude, course, speed, time).
// out_ch gives one record descriptor per fix: status, frame kind, slot in the
// current sector, record count of a sector just closed, and the five deltas
// of a diff record.
// A fix is captured in an input register, then classified against the last
// stored fix and written to the result register, which offers it on out_ch.
// One fix is taken every cycle while out_ch does not stall; the rate is set
// by the single classify step between the two registers, which also updates
// the stored fix and sector tracker.
// When out_ch stalls, the result register holds and the input register
// fills; in_ch.ready then drops until the result is taken.
// Reset (rst_n low, synchronous) empties both registers, clears the stored
// fix and record count and sets the sector offset to the header size; the
// next stored fix is a control record.
module gps_fix_delta_record_packer_core (
  input  logic             clk,
  input  logic             rst_n,
  gfdrp_fix_if.sink        in_ch,
  gfdrp_rec_if.source      out_ch
);

  logic              s1_valid_r;
  gfdrp_pkg::fix_t   fix_r;
  logic              out_valid_r;
  gfdrp_pkg::rec_t   rec_r;
  gfdrp_pkg::state_t state_r;
  gfdrp_pkg::eval_t  ev;
  logic              adv;
  logic              in_xfer;

  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  gfdrp_fix_eval u_eval (
    .fix (fix_r),
    .st  (state_r),
    .ev  (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fix_r.lat_microdeg   <= in_ch.lat_microdeg;
      fix_r.lon_microdeg   <= in_ch.lon_microdeg;
      fix_r.alt_decimetres <= in_ch.alt_decimetres;
      fix_r.course_tenths  <= in_ch.course_tenths;
      fix_r.speed_tenths   <= in_ch.speed_tenths;
      fix_r.time_seconds   <= in_ch.time_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rec_r <= ev.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{offset: gfdrp_pkg::OFS_HEADER, default: '0};
    end else if (adv && ev.store) begin
      state_r <= ev.st_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = rec_r.status;
  assign out_ch.frame_kind    = rec_r.frame_kind;
  assign out_ch.record_slot   = rec_r.record_slot;
  assign out_ch.flushed_count = rec_r.flushed_count;
  assign out_ch.delta_lat     = rec_r.delta_lat;
  assign out_ch.delta_lon     = rec_r.delta_lon;
  assign out_ch.delta_alt     = rec_r.delta_alt;
  assign out_ch.delta_course  = rec_r.delta_course;
  assign out_ch.delta_speed   = rec_r.delta_speed;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while both stages are held");

  a_offset_in_sector: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.offset <= gfdrp_pkg::OFS_SECTOR)
    else $error("sector offset beyond sector size");

  a_flush_restarts_count: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && ev.rec.status == gfdrp_pkg::ST_FLUSHED) |=> (state_r.count == 7'd1))
    else $error("record count not restarted after flush");

  a_reject_is_bare: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (rec_r.status == gfdrp_pkg::ST_SAME ||
                     rec_r.status == gfdrp_pkg::ST_INVALID))
    |-> (rec_r.frame_kind == gfdrp_pkg::KIND_DIFF && rec_r.record_slot == 7'd0))
    else $error("rejected fix carries record fields");

endmodule

@@ design/gfdrp_fix_eval.sv @@
// Classifies one fix against the last stored fix and the sector tracker.
`timescale 1ns / 1ps

module gfdrp_fix_eval (
  input  gfdrp_pkg::fix_t   fix,
  input  gfdrp_pkg::state_t st,
  output gfdrp_pkg::eval_t  ev
);

  logic               invalid;
  logic               same;
  logic               gap;
  logic               kind_pre;
  logic               flush;
  logic signed [32:0] d_lat, d_lon, d_alt, d_course, d_speed;
  logic        [6:0]  slot;
  gfdrp_pkg::ofs_t    size;

  always_comb begin
    invalid = (fix.lat_microdeg < -gfdrp_pkg::COORD_LIMIT) ||
              (fix.lat_microdeg >  gfdrp_pkg::COORD_LIMIT) ||
              (fix.lon_microdeg < -gfdrp_pkg::COORD_LIMIT) ||
              (fix.lon_microdeg >  gfdrp_pkg::COORD_LIMIT) ||
              (fix.time_seconds < gfdrp_pkg::TIME_LOW) ||
              (fix.time_seconds > gfdrp_pkg::TIME_HIGH);
    same = (fix.time_seconds == st.time_s);
    gap  = {1'b0, fix.time_seconds} > ({1'b0, st.time_s} + 33'd1);

    d_lat    = {fix.lat_microdeg[31], fix.lat_microdeg} - {st.lat[31], st.lat};
    d_lon    = {fix.lon_microdeg[31], fix.lon_microdeg} - {st.lon[31], st.lon};
    d_alt    = {{9{fix.alt_decimetres[23]}}, fix.alt_decimetres}
             - {{9{st.alt[23]}}, st.alt};
    d_course = {21'd0, fix.course_tenths} - {21'd0, st.course};
    d_speed  = {17'd0, fix.speed_tenths} - {17'd0, st.speed};

    kind_pre = !st.have || gap ||
               !gfdrp_pkg::delta_small(d_lat) || !gfdrp_pkg::delta_small(d_lon) ||
               !gfdrp_pkg::delta_small(d_alt) || !gfdrp_pkg::delta_small(d_course) ||
               !gfdrp_pkg::delta_small(d_speed);

    // A record that would overflow the sector opens a new one as a control record
    flush = kind_pre ? (st.offset > gfdrp_pkg::LIM_CTRL)
                     : (st.offset > gfdrp_pkg::LIM_DIFF);
    size  = (kind_pre || flush) ? gfdrp_pkg::OFS_CTRL : gfdrp_pkg::OFS_DIFF;
    slot  = flush ? 7'd0 : st.count;

    ev.store = !invalid && !same;

    ev.rec = '0;
    if (invalid) begin
      ev.rec.status = gfdrp_pkg::ST_INVALID;
    end else if (same) begin
      ev.rec.status = gfdrp_pkg::ST_SAME;
    end else begin
      ev.rec.status        = flush ? gfdrp_pkg::ST_FLUSHED : gfdrp_pkg::ST_STORED;
      ev.rec.frame_kind    = (kind_pre || flush) ? gfdrp_pkg::KIND_CTRL
                                                 : gfdrp_pkg::KIND_DIFF;
      ev.rec.record_slot   = slot;
      ev.rec.flushed_count = flush ? st.count : 7'd0;
      if (!(kind_pre || flush)) begin
        ev.rec.delta_lat    = d_lat[7:0];
        ev.rec.delta_lon    = d_lon[7:0];
        ev.rec.delta_alt    = d_alt[7:0];
        ev.rec.delta_course = d_course[7:0];
        ev.rec.delta_speed  = d_speed[7:0];
      end
    end

    ev.st_nxt.lat    = fix.lat_microdeg;
    ev.st_nxt.lon    = fix.lon_microdeg;
    ev.st_nxt.alt    = fix.alt_decimetres;
    ev.st_nxt.course = fix.course_tenths;
    ev.st_nxt.speed  = fix.speed_tenths;
    ev.st_nxt.time_s = fix.time_seconds;
    ev.st_nxt.offset = (flush ? gfdrp_pkg::OFS_HEADER : st.offset) + size;
    ev.st_nxt.count  = slot + 7'd1;
    ev.st_nxt.have   = 1'b1;
  end

endmodule

@@ bench/gfdrp_record_checker.sv @@
// Record checker: predicts each descriptor from accepted fixes and compares transfers.
`timescale 1ns / 1ps

module gfdrp_record_checker
  import gfdrp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  gfdrp_fix_if fix_mon,
  gfdrp_rec_if rec_mon,
  output int   mismatches,
  output int   outstanding
);

  localparam longint DELTA_LIMIT = 127;

  // Last stored fix and sector tracker
  logic signed [31:0] last_lat;
  logic signed [31:0] last_lon;
  logic signed [23:0] last_alt;
  logic        [11:0] last_course;
  logic        [15:0] last_speed;
  logic        [31:0] last_time;
  logic               have_fix;
  int                 sector_fill;
  logic        [6:0]  sector_records;

  rec_t expected_records[$];
  rec_t want_rec;
  fix_t got_fix;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic rec_t classify_fix(fix_t f);
    rec_t   r;
    longint deltas[5];
    logic   kind;
    int     rec_bytes;
    r = '0;
    r.status = ST_STORED;
    if (f.lat_microdeg < -COORD_LIMIT || f.lat_microdeg > COORD_LIMIT ||
        f.lon_microdeg < -COORD_LIMIT || f.lon_microdeg > COORD_LIMIT ||
        f.time_seconds < TIME_LOW || f.time_seconds > TIME_HIGH) begin
      r.status = ST_INVALID;
      return r;
    end
    if (f.time_seconds == last_time) begin
      r.status = ST_SAME;
      return r;
    end
    deltas[0] = longint'(f.lat_microdeg) - longint'(last_lat);
    deltas[1] = longint'(f.lon_microdeg) - longint'(last_lon);
    deltas[2] = longint'(f.alt_decimetres) - longint'(last_alt);
    deltas[3] = longint'(f.course_tenths) - longint'(last_course);
    deltas[4] = longint'(f.speed_tenths) - longint'(last_speed);

    // backwards time is not a gap, only a jump of two or more seconds is
    kind = KIND_DIFF;
    if (!have_fix || longint'(f.time_seconds) > longint'(last_time) + 1)
      kind = KIND_CTRL;
    foreach (deltas[i])
      if (deltas[i] > DELTA_LIMIT || deltas[i] < -DELTA_LIMIT)
        kind = KIND_CTRL;

    rec_bytes = (kind == KIND_CTRL) ? CONTROL_BYTES : DIFF_BYTES;
    if (sector_fill > SECTOR_BYTES - rec_bytes) begin
      // sector closes; the record opens the next one as a control record
      r.status        = ST_FLUSHED;
      r.flushed_count = sector_records;
      sector_fill     = HEADER_BYTES;
      sector_records  = '0;
      kind            = KIND_CTRL;
      rec_bytes       = CONTROL_BYTES;
    end

    r.frame_kind  = kind;
    r.record_slot = sector_records;
    sector_fill    += rec_bytes;
    sector_records += 7'd1;

    if (kind == KIND_DIFF) begin
      r.delta_lat    = 8'(deltas[0]);
      r.delta_lon    = 8'(deltas[1]);
      r.delta_alt    = 8'(deltas[2]);
      r.delta_course = 8'(deltas[3]);
      r.delta_speed  = 8'(deltas[4]);
    end

    last_lat    = f.lat_microdeg;
    last_lon    = f.lon_microdeg;
    last_alt    = f.alt_decimetres;
    last_course = f.course_tenths;
    last_speed  = f.speed_tenths;
    last_time   = f.time_seconds;
    have_fix    = 1'b1;
    return r;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("record field %s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      last_lat       = '0;
      last_lon       = '0;
      last_alt       = '0;
      last_course    = '0;
      last_speed     = '0;
      last_time      = '0;
      have_fix       = 1'b0;
      sector_fill    = HEADER_BYTES;
      sector_records = '0;
      expected_records.delete();
    end else begin
      // an output transfer always belongs to an older fix, so check it first
      if (rec_mon.valid && rec_mon.ready) begin
        if (expected_records.size() == 0) begin
          $error("record transfer with no fix outstanding");
          mismatches++;
        end else begin
          want_rec = expected_records.pop_front();
          check_field("status", longint'(want_rec.status), longint'(rec_mon.status));
          check_field("frame_kind", want_rec.frame_kind, rec_mon.frame_kind);
          check_field("record_slot", want_rec.record_slot, rec_mon.record_slot);
          check_field("flushed_count", want_rec.flushed_count, rec_mon.flushed_count);
          check_field("delta_lat", want_rec.delta_lat, rec_mon.delta_lat);
          check_field("delta_lon", want_rec.delta_lon, rec_mon.delta_lon);
          check_field("delta_alt", want_rec.delta_alt, rec_mon.delta_alt);
          check_field("delta_course", want_rec.delta_course, rec_mon.delta_course);
          check_field("delta_speed", want_rec.delta_speed, rec_mon.delta_speed);
        end
      end
      if (fix_mon.valid && fix_mon.ready) begin
        got_fix.lat_microdeg   = fix_mon.lat_microdeg;
        got_fix.lon_microdeg   = fix_mon.lon_microdeg;
        got_fix.alt_decimetres = fix_mon.alt_decimetres;
        got_fix.course_tenths  = fix_mon.course_tenths;
        got_fix.speed_tenths   = fix_mon.speed_tenths;
        got_fix.time_seconds   = fix_mon.time_seconds;
        expected_records.push_back(classify_fix(got_fix));
      end
    end
    outstanding = expected_records.size();
  end

endmodule

@@ bench/gps_fix_delta_record_packer_core_tb.sv @@
// Testbench top: fix stimulus, receiver back-pressure and the final verdict.
`timescale 1ns / 1ps

module gps_fix_delta_record_packer_core_tb;
  import gfdrp_pkg::*;

  logic clk;
  logic rst_n;
  int   src_idle_pct;
  int   snk_idle_pct;
  bit   rx_hold;
  int   mismatches;
  int   outstanding;
  fix_t trk;

  gfdrp_fix_if fix_ch ();
  gfdrp_rec_if rec_ch ();

  gps_fix_delta_record_packer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (fix_ch),
    .out_ch (rec_ch)
  );

  gfdrp_record_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .fix_mon     (fix_ch),
    .rec_mon     (rec_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("gps_fix_delta_record_packer_core test failed");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    rec_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        rx_hold = 1'b0;
        rec_ch.ready <= 1'b0;
        repeat (150) @(posedge clk);
      end
      rec_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int step_delta();
    return int'($urandom_range(254)) - 127;
  endfunction

  // Offers one fix and returns at the edge of its transfer
  task automatic push_fix(int lat, int lon, int alt, int course, int speed,
                          logic [31:0] secs);
    while ($urandom_range(99) < src_idle_pct) begin
      fix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    fix_ch.valid          <= 1'b1;
    fix_ch.lat_microdeg   <= lat;
    fix_ch.lon_microdeg   <= lon;
    fix_ch.alt_decimetres <= 24'(alt);
    fix_ch.course_tenths  <= 12'(course);
    fix_ch.speed_tenths   <= 16'(speed);
    fix_ch.time_seconds   <= secs;
    do @(posedge clk); while (!fix_ch.ready);
  endtask

  // step to the next edge first so the checker has taken the last transfer
  task automatic drain_results();
    fix_ch.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  task automatic directed_fixes();
    logic [31:0] t0;
    t0 = TIME_LOW + 32'd1000;
    push_fix(0, 0, 0, 0, 0, t0);                    // first fix
    push_fix(5, 5, 5, 5, 5, t0);                    // same second
    push_fix(180000001, 0, 0, 0, 0, t0 + 1);        // coordinate limits
    push_fix(-180000001, 0, 0, 0, 0, t0 + 1);
    push_fix(0, 180000001, 0, 0, 0, t0 + 1);
    push_fix(0, -180000001, 0, 0, 0, t0 + 1);
    push_fix(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, t0 + 1);
    push_fix(0, 0, 0, 0, 0, TIME_LOW - 1);          // time window
    push_fix(0, 0, 0, 0, 0, TIME_HIGH + 1);
    push_fix(0, 0, 0, 0, 0, 32'd0);
    push_fix(0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    push_fix(127, -127, 127, 127, 127, t0 + 1);     // largest diff deltas
    push_fix(0, 0, 0, 0, 0, t0 + 2);
    push_fix(128, 0, 0, 0, 0, t0 + 3);              // just too large
    push_fix(128, 0, -128, 0, 0, t0 + 4);
    push_fix(128, 0, -128, 0, 0, t0 + 6);           // gap
    push_fix(130, 2, -126, 2, 2, t0 + 5);           // time backwards
    push_fix(180000000, -180000000, -8388608, 0, 0, TIME_LOW);
    push_fix(-180000000, 180000000, 8388607, 3600, 65535, TIME_HIGH);
    push_fix(-180000000, 180000000, 8388607, 3600, 65535, TIME_HIGH);
    push_fix(-179999873, 179999873, 8388480, 3473, 65408, TIME_HIGH - 1);
  endtask

  // Mostly one-second tracks with random content, some gaps, jumps and noise
  task automatic run_phase(int n_items);
    int pick;
    int idx;
    int bump;
    int dv[5];
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 4)
        drain_results();
      if (i == n_items / 2)
        rx_hold = 1'b1;
      pick = $urandom_range(99);
      if (pick < 4) begin
        push_fix($urandom, $urandom, $urandom, $urandom_range(3600),
                 $urandom_range(65535), $urandom);
      end else if (pick < 8) begin
        push_fix(trk.lat_microdeg, trk.lon_microdeg, trk.alt_decimetres,
                 $urandom_range(3600), trk.speed_tenths, trk.time_seconds);
      end else begin
        if (pick < 12 || trk.time_seconds < TIME_LOW ||
            trk.time_seconds > TIME_HIGH - 200) begin
          trk.lat_microdeg   = int'($urandom_range(360000000)) - COORD_LIMIT;
          trk.lon_microdeg   = int'($urandom_range(360000000)) - COORD_LIMIT;
          trk.alt_decimetres = 24'($urandom_range(16777215));
          trk.course_tenths  = 12'($urandom_range(3600));
          trk.speed_tenths   = 16'($urandom_range(65535));
          trk.time_seconds   = TIME_LOW + $urandom_range(TIME_HIGH - TIME_LOW - 1000);
        end else begin
          if (pick < 18)
            trk.time_seconds = trk.time_seconds + 32'($urandom_range(2, 100));
          else if (pick < 22 && trk.time_seconds > TIME_LOW + 10)
            trk.time_seconds = trk.time_seconds - 32'($urandom_range(1, 5));
          else
            trk.time_seconds = trk.time_seconds + 32'd1;
          foreach (dv[k])
            dv[k] = step_delta();
          if (pick >= 22 && pick < 32) begin
            idx  = $urandom_range(4);
            bump = $urandom_range(128, 5000);
            dv[idx] = $urandom_range(1) ? bump : -bump;
          end
          trk.lat_microdeg = 32'(clamp(longint'(trk.lat_microdeg) + dv[0],
                                       -COORD_LIMIT, COORD_LIMIT));
          trk.lon_microdeg = 32'(clamp(longint'(trk.lon_microdeg) + dv[1],
                                       -COORD_LIMIT, COORD_LIMIT));
          trk.alt_decimetres = 24'(clamp(longint'(trk.alt_decimetres) + dv[2],
                                         -8388608, 8388607));
          trk.course_tenths = 12'(clamp(longint'(trk.course_tenths) + dv[3], 0, 3600));
          trk.speed_tenths  = 16'(clamp(longint'(trk.speed_tenths) + dv[4], 0, 65535));
        end
        push_fix(trk.lat_microdeg, trk.lon_microdeg, trk.alt_decimetres,
                 trk.course_tenths, trk.speed_tenths, trk.time_seconds);
      end
    end
  endtask

  initial begin
    rst_n                 = 1'b0;
    rx_hold               = 1'b0;
    src_idle_pct          = 18;
    snk_idle_pct          = 69;
    trk                   = '0;
    fix_ch.valid          = 1'b0;
    fix_ch.lat_microdeg   = '0;
    fix_ch.lon_microdeg   = '0;
    fix_ch.alt_decimetres = '0;
    fix_ch.course_tenths  = '0;
    fix_ch.speed_tenths   = '0;
    fix_ch.time_seconds   = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    directed_fixes();
    run_phase(560);
    drain_results();

    src_idle_pct = 69;
    snk_idle_pct = 18;
    run_phase(585);
    drain_results();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_phase(585);

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("gps_fix_delta_record_packer_core test passed");
    else
      $display("gps_fix_delta_record_packer_core test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
design/gfdrp_pkg.sv
design/gfdrp_fix_if.sv
design/gfdrp_rec_if.sv
design/gfdrp_fix_eval.sv
design/gps_fix_delta_record_packer_core.sv
bench/gfdrp_record_checker.sv
bench/gps_fix_delta_record_packer_core_tb.sv
